### hw/rtl/ordered_multiset_engine_defines.svh
// Assertion macros for the ordered multiset engine
`ifndef ORDERED_MULTISET_ENGINE_DEFINES_SVH
`define ORDERED_MULTISET_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define OME_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the next cycle
`define OME_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OME_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define OME_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/ome_pkg.sv
`timescale 1ns / 1ps
package ome_pkg;
  localparam int CAP = 1024;
  localparam int AW  = $clog2(CAP);
  localparam int CW  = AW + 1;
  localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;

  typedef enum logic [2:0] {
    CMD_INS  = 3'd0,
    CMD_DEL1 = 3'd1,
    CMD_DLT  = 3'd2,
    CMD_DGT  = 3'd3,
    CMD_DIV  = 3'd4,
    CMD_FIND = 3'd5,
    CMD_RANK = 3'd6,
    CMD_NONE = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    AS_SCAN = 2'd0,
    AS_INS  = 2'd1,
    AS_RANK = 2'd2
  } addr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      rd_en;
    addr_sel_t addr_sel;
    logic      scan_ev;
    logic      ins_shift;
    logic      ins_wr;
    logic      cnt_wp;
    logic      out_load;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic scan_last;
    logic ins_gt;
    logic ins_last;
    logic rank_ok;
    logic ival_ok;
    logic out_busy;
  } stat_t;
endpackage

### hw/rtl/ome_if.sv
`timescale 1ns / 1ps
interface ome_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [31:0] key;
  logic signed [31:0] key_high;
  logic [10:0]        rank;
  modport source (output valid, cmd, key, key_high, rank, input ready);
  modport sink   (input valid, cmd, key, key_high, rank, output ready);
endinterface

interface ome_out_if;
  logic               valid;
  logic               ready;
  logic               reply_kind;
  logic               found;
  logic signed [31:0] value;
  modport source (output valid, reply_kind, found, value, input ready);
  modport sink   (input valid, reply_kind, found, value, output ready);
endinterface

### hw/rtl/ome_ctrl.sv
`timescale 1ns / 1ps
module ome_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ome_pkg::stat_t st,
  output ome_pkg::ctl_t  ctl
);
  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_DISP    = 10'b00_0000_0010,
    S_SCAN_RD = 10'b00_0000_0100,
    S_SCAN_EV = 10'b00_0000_1000,
    S_FIN     = 10'b00_0001_0000,
    S_INS_RD  = 10'b00_0010_0000,
    S_INS_EV  = 10'b00_0100_0000,
    S_INS_WR  = 10'b00_1000_0000,
    S_RANK_RD = 10'b01_0000_0000,
    S_REPLY   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    ctl          = '0;
    ctl.addr_sel = ome_pkg::AS_SCAN;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.cmd)
          ome_pkg::CMD_INS: begin
            if (st.full) state_nxt = S_IDLE;
            else if (st.empty) state_nxt = S_INS_WR;
            else state_nxt = S_INS_RD;
          end
          ome_pkg::CMD_DEL1, ome_pkg::CMD_DLT, ome_pkg::CMD_DGT,
          ome_pkg::CMD_FIND: begin
            state_nxt = st.empty ? S_FIN : S_SCAN_RD;
          end
          ome_pkg::CMD_DIV: begin
            if (!st.ival_ok) state_nxt = S_IDLE;
            else state_nxt = st.empty ? S_FIN : S_SCAN_RD;
          end
          ome_pkg::CMD_RANK: state_nxt = st.rank_ok ? S_RANK_RD : S_REPLY;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SCAN_RD: begin
        ctl.rd_en = 1'b1;
        state_nxt = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        ctl.scan_ev = 1'b1;
        state_nxt   = st.scan_last ? S_FIN : S_SCAN_RD;
      end
      S_FIN: begin
        if (st.cmd == ome_pkg::CMD_FIND) state_nxt = S_REPLY;
        else begin
          ctl.cnt_wp = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_INS_RD: begin
        ctl.rd_en    = 1'b1;
        ctl.addr_sel = ome_pkg::AS_INS;
        state_nxt    = S_INS_EV;
      end
      S_INS_EV: begin
        if (st.ins_gt) begin
          ctl.ins_shift = 1'b1;
          state_nxt     = st.ins_last ? S_INS_WR : S_INS_RD;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        ctl.ins_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_RANK_RD: begin
        ctl.rd_en    = 1'b1;
        ctl.addr_sel = ome_pkg::AS_RANK;
        state_nxt    = S_REPLY;
      end
      S_REPLY: begin
        if (!st.out_busy) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

### hw/rtl/ome_dp.sv
`timescale 1ns / 1ps
`include "ordered_multiset_engine_defines.svh"
module ome_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  ome_pkg::ctl_t  ctl,
  output ome_pkg::stat_t st,
  ome_in_if.sink         in_ch,
  ome_out_if.source      out_ch
);
  // sorted store, keys kept with the sign bit flipped
  logic [31:0] mem [ome_pkg::CAP];

  ome_pkg::cmd_t            cmd_r;
  logic [31:0]              k_r, kh_r, rd_r;
  logic [10:0]              rank_r;
  logic [ome_pkg::CW-1:0]   cnt_r, rp_r, wp_r;
  logic                     hit_r;
  logic                     ov_r, okind_r, ofound_r;
  logic [31:0]              oval_r;

  logic                     we;
  logic [ome_pkg::AW-1:0]   waddr, raddr;
  logic [31:0]              wdata;
  logic                     eq, drop;

  assign eq = (rd_r == k_r);

  // removal test for the compaction scan
  always_comb begin
    unique case (cmd_r)
      ome_pkg::CMD_DEL1: drop = eq && !hit_r;
      ome_pkg::CMD_DLT:  drop = rd_r < k_r;
      ome_pkg::CMD_DGT:  drop = rd_r > k_r;
      ome_pkg::CMD_DIV:  drop = (rd_r > k_r) && (rd_r < kh_r);
      default:           drop = 1'b0;
    endcase
  end

  // store write and read addresses
  always_comb begin
    we    = 1'b0;
    waddr = wp_r[ome_pkg::AW-1:0];
    wdata = rd_r;
    if (ctl.scan_ev && cmd_r != ome_pkg::CMD_FIND && !drop) we = 1'b1;
    if (ctl.ins_shift) begin
      we    = 1'b1;
      waddr = rp_r[ome_pkg::AW-1:0];
    end
    if (ctl.ins_wr) begin
      we    = 1'b1;
      waddr = rp_r[ome_pkg::AW-1:0];
      wdata = k_r;
    end
    unique case (ctl.addr_sel)
      ome_pkg::AS_INS:  raddr = ome_pkg::AW'(rp_r - 1'b1);
      ome_pkg::AS_RANK: raddr = ome_pkg::AW'(rank_r - 11'd1);
      default:          raddr = rp_r[ome_pkg::AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (ctl.rd_en) rd_r <= mem[raddr];
  end

  // captured word and pointers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= ome_pkg::cmd_t'(in_ch.cmd);
      k_r    <= in_ch.key ^ ome_pkg::SIGN_BIAS;
      kh_r   <= in_ch.key_high ^ ome_pkg::SIGN_BIAS;
      rank_r <= in_ch.rank;
      rp_r   <= (ome_pkg::cmd_t'(in_ch.cmd) == ome_pkg::CMD_INS) ? cnt_r : '0;
      wp_r   <= '0;
      hit_r  <= 1'b0;
    end
    if (ctl.scan_ev) begin
      rp_r  <= rp_r + 1'b1;
      hit_r <= hit_r | eq;
      if (we) wp_r <= wp_r + 1'b1;
    end
    if (ctl.ins_shift) rp_r <= rp_r - 1'b1;
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (ctl.ins_wr) cnt_r <= cnt_r + 1'b1;
    else if (ctl.cnt_wp) cnt_r <= wp_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (ctl.out_load) ov_r <= 1'b1;
    else if (out_ch.ready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      okind_r <= (cmd_r == ome_pkg::CMD_RANK);
      if (cmd_r == ome_pkg::CMD_RANK) begin
        ofound_r <= st.rank_ok;
        oval_r   <= st.rank_ok ? (rd_r ^ ome_pkg::SIGN_BIAS) : 32'd0;
      end else begin
        ofound_r <= hit_r;
        oval_r   <= 32'd0;
      end
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.reply_kind = okind_r;
  assign out_ch.found      = ofound_r;
  assign out_ch.value      = oval_r;

  // status
  assign st.cmd       = cmd_r;
  assign st.full      = (32'(cnt_r) >= ome_pkg::CAP);
  assign st.empty     = (cnt_r == '0);
  assign st.scan_last = (rp_r + 1'b1 == cnt_r);
  assign st.ins_gt    = (rd_r > k_r);
  assign st.ins_last  = (rp_r == ome_pkg::CW'(1));
  assign st.rank_ok   = (rank_r != 11'd0) && (32'(rank_r) <= 32'(cnt_r));
  assign st.ival_ok   = (k_r < kh_r);
  assign st.out_busy  = ov_r && !out_ch.ready;

  `OME_ASSERT_IMP(a_cnt_cap, clk, rst_n, 1'b1, 32'(cnt_r) <= ome_pkg::CAP, "count over capacity")
  `OME_ASSERT_IMP(a_wp_le_rp, clk, rst_n, ctl.scan_ev, wp_r <= rp_r, "write ahead of read")
  `OME_ASSERT_IMP(a_out_free, clk, rst_n, ctl.out_load, !ov_r || out_ch.ready, "reply overwritten")
  `OME_ASSERT_NXT(a_ins_grow, clk, rst_n, ctl.ins_wr, cnt_r == $past(cnt_r) + 1'b1, "insert count")
endmodule

### hw/rtl/ordered_multiset_engine.sv
`timescale 1ns / 1ps
// Ordered multiset of signed 32-bit keys, duplicates allowed, up to 1024 held.
// in_ch carries one command word (cmd, key, key_high, rank); it is taken when
// valid and ready are high at a clock edge. Ready is high only while idle.
// out_ch carries one reply word (reply_kind, found, value) for find and rank
// commands; other commands give none.
// A rank query reads at most one entry; an insert moves each larger entry
// up by one, from the back; deletes and find scan every held entry once;
// an insert to a full set, an interval whose key_high is not above key and
// the unused code 7 are dropped without a store access.
// The store is used for one read and one write per entry step, with a
// registered read.
// The reply sits in an output register; a new command may be taken while it
// waits. A later reply waits in the controller until the receiver takes the
// earlier one, so a stalled receiver stalls the input only then.
// Reset (rst_n low, synchronous) empties the set at once; store contents are
// left as they are and never read before written.
module ordered_multiset_engine (
  input logic       clk,
  input logic       rst_n,
  ome_in_if.sink    in_ch,
  ome_out_if.source out_ch
);
  ome_pkg::ctl_t  ctl;
  ome_pkg::stat_t st;

  ome_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .ctl      (ctl)
  );

  ome_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .st     (st),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );
endmodule
